### sv/ttb_pkg.sv
package ttb_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W  = 24;
    localparam int TEX_W  = 17;
    localparam int VEC_W  = 32;

    localparam int DP_W   = POS_W + 1;
    localparam int DT_W   = TEX_W + 1;
    localparam int PROD_W = DP_W + DT_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DET_W  = 2 * DT_W + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic        [TEX_W-1:0] tex_u;
        logic        [TEX_W-1:0] tex_v;
    } vertex_word_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] tangent_x;
        logic signed [VEC_W-1:0] tangent_y;
        logic signed [VEC_W-1:0] tangent_z;
        logic signed [VEC_W-1:0] bitangent_x;
        logic signed [VEC_W-1:0] bitangent_y;
        logic signed [VEC_W-1:0] bitangent_z;
        logic                    degenerate;
        logic                    saturated;
    } basis_word_t;

endpackage

### sv/triangle_tangent_bitangent.sv
// Tangent and bitangent of each triangle in a vertex stream.
// vertex channel: one word per vertex (Q8.16 position, Q1.16 texcoord).
// Three consecutive vertices form a triangle; the first two are only held
// and accepted whenever the sequencer is idle, the third starts the computation.
// basis channel: one word per triangle, tangent and bitangent in Q16.16,
// truncated toward zero and clamped, with degenerate and saturated flags.
// The third vertex starts the sequencer: the determinant first, then each of
// the six components in turn (through the shared 25x18 multiplier, a
// magnitude and range check, the one-bit restoring divider, skipped for a
// component out of range, and a clamp), then the load of the output
// register; a zero determinant skips the six components. vertex_stall is
// high all the while the sequencer is busy.
// A finished word waits in the output register; a new triangle may be
// computed meanwhile, but it holds in its last step while basis_stall
// keeps the previous word in place.
// Reset clears the vertex count, so the next vertex starts a triangle, and
// drops basis_valid.
module triangle_tangent_bitangent
    import ttb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vertex_valid,
    output logic         vertex_stall,
    input  vertex_word_t vertex,
    output logic         basis_valid,
    input  logic         basis_stall,
    output basis_word_t  basis
);

    localparam int D_UW   = DET_W;
    localparam int T_W    = D_UW + 1;
    localparam int CNT_W  = $clog2(VEC_W);
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] IDX_BITAN = 3'd3;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'd5;
    localparam logic [IDX_W-1:0] IDX_DET   = 3'd6;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUB,
        ST_DET_CHK,
        ST_ABS,
        ST_DIV_CHK,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_FIN
    } state_t;

    state_t               state_reg;
    logic [1:0]           phase_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_valid_reg;
    basis_word_t          out_reg;

    logic signed [POS_W-1:0]  p0_reg [3];
    logic signed [POS_W-1:0]  p1_reg [3];
    logic [TEX_W-1:0]         u0_reg, v0_reg, u1_reg, v1_reg;

    logic signed [DP_W-1:0]   dp1_reg [3];
    logic signed [DP_W-1:0]   dp2_reg [3];
    logic signed [DT_W-1:0]   du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NUM_W-1:0]  acc_reg;
    logic [D_UW-1:0]          d_reg;
    logic                     det_neg_reg;
    logic [NUM_W-1:0]         n_reg;
    logic                     neg_reg;
    logic                     big_reg;
    logic [D_UW-1:0]          rem_reg;
    logic [VEC_W-1:0]         low_reg;
    logic                     sat_reg;
    logic                     degen_reg;
    logic signed [VEC_W-1:0]  res_reg [6];

    logic signed [POS_W-1:0]  vin_p [3];
    logic                     accept;
    logic [1:0]               comp;
    logic signed [DP_W-1:0]   mul_a;
    logic signed [DT_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_full;
    logic [D_UW-1:0]          rem_init;
    logic [T_W-1:0]           trial;
    logic                     trial_ge;
    logic [VEC_W-1:0]         lim;
    logic                     over;
    logic [VEC_W-1:0]         mag;
    logic                     out_load;

    assign vin_p[0] = vertex.pos_x;
    assign vin_p[1] = vertex.pos_y;
    assign vin_p[2] = vertex.pos_z;

    assign vertex_stall = (state_reg != ST_IDLE);
    assign accept       = vertex_valid && !vertex_stall;
    assign basis_valid  = out_valid_reg;
    assign basis        = out_reg;
    assign out_load     = (state_reg == ST_FIN) && (!out_valid_reg || !basis_stall);

    // shared multiplier operand selection
    always_comb
    begin
        comp  = (idx_reg >= IDX_BITAN) ? 2'(idx_reg - IDX_BITAN) : idx_reg[1:0];
        mul_a = '0;
        mul_b = '0;
        if (idx_reg == IDX_DET)
        begin
            mul_a = (state_reg == ST_MUL_A) ? DP_W'(du1_reg) : DP_W'(dv1_reg);
            mul_b = (state_reg == ST_MUL_A) ? dv2_reg : du2_reg;
        end
        else if (idx_reg < IDX_BITAN)
        begin
            mul_a = (state_reg == ST_MUL_A) ? dp1_reg[comp] : dp2_reg[comp];
            mul_b = (state_reg == ST_MUL_A) ? dv2_reg : dv1_reg;
        end
        else
        begin
            mul_a = (state_reg == ST_MUL_A) ? dp2_reg[comp] : dp1_reg[comp];
            mul_b = (state_reg == ST_MUL_A) ? du1_reg : du2_reg;
        end
    end

    assign prod_full = mul_a * mul_b;

    // divider step and clamp
    assign rem_init = D_UW'(n_reg >> (VEC_W - FRAC_BITS));
    assign trial    = {rem_reg, low_reg[VEC_W-1]};
    assign trial_ge = (trial >= T_W'(d_reg));
    assign lim      = neg_reg ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
    assign over     = big_reg || (low_reg > lim);
    assign mag      = over ? lim : low_reg;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FIRST;
            idx_reg       <= IDX_DET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !basis_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (phase_reg)
                            PH_SECOND:
                            begin
                                phase_reg <= PH_THIRD;
                            end
                            PH_THIRD:
                            begin
                                phase_reg <= PH_FIRST;
                                idx_reg   <= IDX_DET;
                                state_reg <= ST_MUL_A;
                            end
                            default:
                            begin
                                phase_reg <= PH_SECOND;
                            end
                        endcase
                    end
                end
                ST_MUL_A:
                begin
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    state_reg <= ST_SUB;
                end
                ST_SUB:
                begin
                    state_reg <= (idx_reg == IDX_DET) ? ST_DET_CHK : ST_ABS;
                end
                ST_DET_CHK:
                begin
                    idx_reg   <= IDX_FIRST;
                    state_reg <= (acc_reg == '0) ? ST_FIN : ST_MUL_A;
                end
                ST_ABS:
                begin
                    state_reg <= ST_DIV_CHK;
                end
                ST_DIV_CHK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (rem_init >= d_reg) ? ST_DIV_DONE : ST_DIV_RUN;
                end
                ST_DIV_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(VEC_W - 1))
                    begin
                        state_reg <= ST_DIV_DONE;
                    end
                end
                ST_DIV_DONE:
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg           <= ST_IDLE;
                        out_reg.tangent_x   <= degen_reg ? '0 : res_reg[0];
                        out_reg.tangent_y   <= degen_reg ? '0 : res_reg[1];
                        out_reg.tangent_z   <= degen_reg ? '0 : res_reg[2];
                        out_reg.bitangent_x <= degen_reg ? '0 : res_reg[3];
                        out_reg.bitangent_y <= degen_reg ? '0 : res_reg[4];
                        out_reg.bitangent_z <= degen_reg ? '0 : res_reg[5];
                        out_reg.degenerate  <= degen_reg;
                        out_reg.saturated   <= !degen_reg && sat_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        p1_reg[i] <= vin_p[i];
                    end
                    u1_reg <= vertex.tex_u;
                    v1_reg <= vertex.tex_v;
                end
                PH_THIRD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dp1_reg[i] <= DP_W'(p1_reg[i]) - DP_W'(p0_reg[i]);
                        dp2_reg[i] <= DP_W'(vin_p[i]) - DP_W'(p0_reg[i]);
                    end
                    du1_reg   <= DT_W'(u1_reg) - DT_W'(u0_reg);
                    dv1_reg   <= DT_W'(v1_reg) - DT_W'(v0_reg);
                    du2_reg   <= DT_W'(vertex.tex_u) - DT_W'(u0_reg);
                    dv2_reg   <= DT_W'(vertex.tex_v) - DT_W'(v0_reg);
                    sat_reg   <= 1'b0;
                    degen_reg <= 1'b0;
                end
                default:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        p0_reg[i] <= vin_p[i];
                    end
                    u0_reg <= vertex.tex_u;
                    v0_reg <= vertex.tex_v;
                end
            endcase
        end

        case (state_reg)
            ST_MUL_A:
            begin
                prod_reg <= prod_full;
            end
            ST_MUL_B:
            begin
                prod_reg <= prod_full;
                acc_reg  <= NUM_W'(prod_reg);
            end
            ST_SUB:
            begin
                acc_reg <= acc_reg - NUM_W'(prod_reg);
            end
            ST_DET_CHK:
            begin
                d_reg       <= acc_reg[NUM_W-1] ? D_UW'(-acc_reg) : D_UW'(acc_reg);
                det_neg_reg <= acc_reg[NUM_W-1];
                if (acc_reg == '0)
                begin
                    degen_reg <= 1'b1;
                end
            end
            ST_ABS:
            begin
                n_reg   <= acc_reg[NUM_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);
                neg_reg <= acc_reg[NUM_W-1] ^ det_neg_reg;
            end
            ST_DIV_CHK:
            begin
                big_reg <= (rem_init >= d_reg);
                rem_reg <= rem_init;
                low_reg <= VEC_W'({n_reg, {FRAC_BITS{1'b0}}});
            end
            ST_DIV_RUN:
            begin
                rem_reg <= trial_ge ? D_UW'(trial - T_W'(d_reg)) : D_UW'(trial);
                low_reg <= {low_reg[VEC_W-2:0], trial_ge};
            end
            ST_DIV_DONE:
            begin
                res_reg[idx_reg] <= neg_reg ? (VEC_W'(0) - mag) : mag;
                if (over)
                begin
                    sat_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (basis_valid && basis.degenerate) |->
            (basis.tangent_x == 0 && basis.tangent_y == 0 && basis.tangent_z == 0 &&
             basis.bitangent_x == 0 && basis.bitangent_y == 0 &&
             basis.bitangent_z == 0 && !basis.saturated))
        else $error("degenerate word with nonzero payload");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_RUN) |-> (d_reg != '0))
        else $error("division by zero determinant");

    a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_THIRD) |=> (state_reg == ST_MUL_A && idx_reg == IDX_DET))
        else $error("third vertex did not start the sequencer");

    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result word loaded outside final step");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_RUN || state_reg == ST_DIV_DONE) |-> (idx_reg <= IDX_LAST))
        else $error("component index out of range during division");

endmodule

### tb/sv/ttb_basis_checker.sv
`timescale 1ns / 100ps

module ttb_basis_checker
    import ttb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vertex_valid,
    input  logic         vertex_stall,
    input  vertex_word_t vertex,
    input  logic         basis_valid,
    input  logic         basis_stall,
    input  basis_word_t  basis,
    output int           errors,
    output int           pending,
    output int           vertices_seen,
    output int           triangles_seen,
    output int           degenerate_seen,
    output int           saturated_seen
);

    localparam logic [1:0] VTX_FIRST  = 2'd0;
    localparam logic [1:0] VTX_SECOND = 2'd1;
    localparam logic [1:0] VTX_THIRD  = 2'd2;

    longint      held_pos [6];
    longint      held_tex [4];
    logic [1:0]  vertex_phase;
    int          words_checked;
    basis_word_t expected_basis [$];

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endtask

    // (num << FRAC_BITS) / den toward zero, clamped to 32 bits; top bit is the clamp flag
    function automatic logic [VEC_W:0] fixed_quotient(input longint num, input longint den);
        bit              neg;
        bit              sat;
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        longint unsigned r;
        longint unsigned mag;
        longint unsigned lim;
        longint unsigned res;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (q >= (64'd1 << (VEC_W - FRAC_BITS)))
            mag = lim + 64'd1;
        else
            mag = (q << FRAC_BITS) + ((r << FRAC_BITS) / d);
        sat = mag > lim;
        if (sat)
            mag = lim;
        res = neg ? 64'd0 - mag : mag;
        return {sat, res[VEC_W-1:0]};
    endfunction

    task automatic absorb_vertex(input vertex_word_t w);
        longint         p [3];
        longint         d1 [3];
        longint         d2 [3];
        longint         u;
        longint         v;
        longint         du1;
        longint         dv1;
        longint         du2;
        longint         dv2;
        longint         det;
        logic [VEC_W:0] tq [3];
        logic [VEC_W:0] bq [3];
        basis_word_t    b;
        int             i;
        p[0] = $signed(w.pos_x);
        p[1] = $signed(w.pos_y);
        p[2] = $signed(w.pos_z);
        u = w.tex_u;
        v = w.tex_v;
        vertices_seen++;
        case (vertex_phase)
            VTX_SECOND:
            begin
                for (i = 0; i < 3; i++)
                    held_pos[3 + i] = p[i];
                held_tex[2] = u;
                held_tex[3] = v;
                vertex_phase = VTX_THIRD;
            end
            VTX_THIRD:
            begin
                vertex_phase = VTX_FIRST;
                for (i = 0; i < 3; i++)
                begin
                    d1[i] = held_pos[3 + i] - held_pos[i];
                    d2[i] = p[i] - held_pos[i];
                end
                du1 = held_tex[2] - held_tex[0];
                dv1 = held_tex[3] - held_tex[1];
                du2 = u - held_tex[0];
                dv2 = v - held_tex[1];
                det = du1 * dv2 - dv1 * du2;
                b = '0;
                if (det == 0)
                    b.degenerate = 1'b1;
                else
                begin
                    for (i = 0; i < 3; i++)
                    begin
                        tq[i] = fixed_quotient(d1[i] * dv2 - d2[i] * dv1, det);
                        bq[i] = fixed_quotient(d2[i] * du1 - d1[i] * du2, det);
                    end
                    b.tangent_x   = tq[0][VEC_W-1:0];
                    b.tangent_y   = tq[1][VEC_W-1:0];
                    b.tangent_z   = tq[2][VEC_W-1:0];
                    b.bitangent_x = bq[0][VEC_W-1:0];
                    b.bitangent_y = bq[1][VEC_W-1:0];
                    b.bitangent_z = bq[2][VEC_W-1:0];
                    b.saturated   = tq[0][VEC_W] | tq[1][VEC_W] | tq[2][VEC_W]
                                  | bq[0][VEC_W] | bq[1][VEC_W] | bq[2][VEC_W];
                end
                triangles_seen++;
                if (b.degenerate)
                    degenerate_seen++;
                if (b.saturated)
                    saturated_seen++;
                expected_basis = {expected_basis, b};
            end
            default:
            begin
                // first vertex; the unused phase also starts a triangle
                for (i = 0; i < 3; i++)
                    held_pos[i] = p[i];
                held_tex[0] = u;
                held_tex[1] = v;
                vertex_phase = VTX_SECOND;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [VEC_W-1:0] got,
                               input logic [VEC_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("basis word %0d %s: got %h expected %h",
                                      words_checked, name, got, want));
    endtask

    task automatic check_basis(input basis_word_t got);
        basis_word_t want;
        if (expected_basis.size() == 0)
        begin
            report_mismatch("basis word with no triangle pending");
            return;
        end
        want = expected_basis.pop_front();
        words_checked++;
        check_field("tangent_x", got.tangent_x, want.tangent_x);
        check_field("tangent_y", got.tangent_y, want.tangent_y);
        check_field("tangent_z", got.tangent_z, want.tangent_z);
        check_field("bitangent_x", got.bitangent_x, want.bitangent_x);
        check_field("bitangent_y", got.bitangent_y, want.bitangent_y);
        check_field("bitangent_z", got.bitangent_z, want.bitangent_z);
        check_field("degenerate", {31'd0, got.degenerate}, {31'd0, want.degenerate});
        check_field("saturated", {31'd0, got.saturated}, {31'd0, want.saturated});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
                held_pos[k] = 0;
            for (int k = 0; k < 4; k++)
                held_tex[k] = 0;
            vertex_phase = VTX_FIRST;
            expected_basis.delete();
            errors = 0;
            words_checked = 0;
            vertices_seen = 0;
            triangles_seen = 0;
            degenerate_seen = 0;
            saturated_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (vertex_valid && !vertex_stall)
                absorb_vertex(vertex);
            if (basis_valid && !basis_stall)
                check_basis(basis);
            pending <= expected_basis.size();
        end
    end

endmodule

### tb/sv/tb_triangle_tangent_bitangent.sv
`timescale 1ns / 100ps

module tb_triangle_tangent_bitangent
    import ttb_pkg::*;
();

    localparam int HOLD_CYCLES      = 1500;
    localparam int STALL_LIMIT      = 20000;
    localparam int DRAIN_CYCLES     = 300;
    localparam int RANDOM_TRIANGLES = 275;

    typedef enum int {
        TRI_SPREAD,
        TRI_LOCAL,
        TRI_DEGENERATE,
        TRI_TINY_DET,
        TRI_WIDE_TEX,
        TRI_EXTREME
    } tri_kind_t;

    logic         clk;
    logic         rst_n;
    logic         vertex_valid;
    logic         vertex_stall;
    vertex_word_t vertex;
    logic         basis_valid;
    logic         basis_stall;
    basis_word_t  basis;

    int errors;
    int pending;
    int vertices_seen;
    int triangles_seen;
    int degenerate_seen;
    int saturated_seen;
    int idle_cycles = 0;
    bit steady = 1'b0;
    bit hold_request = 1'b0;

    triangle_tangent_bitangent dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .basis_valid  (basis_valid),
        .basis_stall  (basis_stall),
        .basis        (basis)
    );

    ttb_basis_checker basis_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .vertex_valid    (vertex_valid),
        .vertex_stall    (vertex_stall),
        .vertex          (vertex),
        .basis_valid     (basis_valid),
        .basis_stall     (basis_stall),
        .basis           (basis),
        .errors          (errors),
        .pending         (pending),
        .vertices_seen   (vertices_seen),
        .triangles_seen  (triangles_seen),
        .degenerate_seen (degenerate_seen),
        .saturated_seen  (saturated_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom());
    endfunction

    function automatic logic [POS_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return 24'h7fffff;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hffffff;
            default: return rand_pos();
        endcase
    endfunction

    function automatic logic [TEX_W-1:0] pick_tex();
        case ($urandom_range(0, 4))
            0:       return 17'h00000;
            1:       return 17'h10000;
            2:       return 17'h1ffff;
            default: return TEX_W'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic vertex_word_t make_vertex(input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] y,
                                                 input logic [POS_W-1:0] z,
                                                 input logic [TEX_W-1:0] u,
                                                 input logic [TEX_W-1:0] v);
        vertex_word_t w;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        w.tex_u = u;
        w.tex_v = v;
        return w;
    endfunction

    task automatic send_vertex(input vertex_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            vertex_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertex <= w;
        vertex_valid <= 1'b1;
        @(posedge clk);
        while (vertex_stall)
            @(posedge clk);
    endtask

    task automatic send_triangle(input vertex_word_t a, input vertex_word_t b,
                                 input vertex_word_t c);
        send_vertex(a);
        send_vertex(b);
        send_vertex(c);
    endtask

    // stop offering and wait for every outstanding basis word
    task automatic drain();
        vertex_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_triangle(input tri_kind_t kind);
        logic [POS_W-1:0] px [3];
        logic [POS_W-1:0] py [3];
        logic [POS_W-1:0] pz [3];
        logic [TEX_W-1:0] tu [3];
        logic [TEX_W-1:0] tv [3];
        logic [TEX_W-1:0] du;
        logic [TEX_W-1:0] dv;
        bit               collinear;
        int               i;
        collinear = $urandom_range(0, 1);
        du = TEX_W'($urandom_range(0, 1000));
        dv = TEX_W'($urandom_range(0, 1000));
        for (i = 0; i < 3; i++)
        begin
            px[i] = rand_pos();
            py[i] = rand_pos();
            pz[i] = rand_pos();
            tu[i] = TEX_W'($urandom_range(0, 65536));
            tv[i] = TEX_W'($urandom_range(0, 65536));
        end
        case (kind)
            TRI_LOCAL:
            begin
                tu[0] = TEX_W'($urandom_range(0, 65000));
                tv[0] = TEX_W'($urandom_range(0, 65000));
                for (i = 1; i < 3; i++)
                begin
                    px[i] = px[0] + POS_W'($urandom_range(0, 8191)) - 24'd4096;
                    py[i] = py[0] + POS_W'($urandom_range(0, 8191)) - 24'd4096;
                    pz[i] = pz[0] + POS_W'($urandom_range(0, 8191)) - 24'd4096;
                    tu[i] = tu[0] + TEX_W'($urandom_range(0, 500));
                    tv[i] = tv[0] + TEX_W'($urandom_range(0, 500));
                end
            end
            TRI_DEGENERATE:
            begin
                tu[0] = TEX_W'($urandom_range(0, 60000));
                tv[0] = TEX_W'($urandom_range(0, 60000));
                tu[1] = collinear ? tu[0] + du : tu[0];
                tv[1] = collinear ? tv[0] + dv : tv[0];
                tu[2] = collinear ? tu[0] + du + du : tu[2];
                tv[2] = collinear ? tv[0] + dv + dv : tv[2];
            end
            TRI_TINY_DET:
            begin
                tu[0] = TEX_W'($urandom_range(0, 65000));
                tv[0] = TEX_W'($urandom_range(0, 65000));
                for (i = 1; i < 3; i++)
                begin
                    tu[i] = tu[0] + TEX_W'($urandom_range(0, 2));
                    tv[i] = tv[0] + TEX_W'($urandom_range(0, 2));
                end
            end
            TRI_WIDE_TEX:
            begin
                for (i = 0; i < 3; i++)
                begin
                    tu[i] = TEX_W'($urandom_range(0, 131071));
                    tv[i] = TEX_W'($urandom_range(0, 131071));
                end
            end
            TRI_EXTREME:
            begin
                for (i = 0; i < 3; i++)
                begin
                    px[i] = pick_coord();
                    py[i] = pick_coord();
                    pz[i] = pick_coord();
                    tu[i] = pick_tex();
                    tv[i] = pick_tex();
                end
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < 3; i++)
            send_vertex(make_vertex(px[i], py[i], pz[i], tu[i], tv[i]));
    endtask

    // sender
    initial
    begin
        tri_kind_t kind;
        int        t;
        int        r;
        rst_n = 1'b0;
        vertex_valid = 1'b0;
        vertex = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit right triangle
        send_triangle(make_vertex('0, '0, '0, '0, '0),
                      make_vertex(24'h010000, '0, '0, 17'h10000, '0),
                      make_vertex('0, 24'h010000, '0, '0, 17'h10000));
        // position extremes
        send_triangle(make_vertex(24'h800000, 24'h800000, 24'h800000, '0, '0),
                      make_vertex(24'h7fffff, 24'h7fffff, 24'h7fffff, 17'h10000, '0),
                      make_vertex(24'h7fffff, 24'h800000, '0, '0, 17'h10000));
        // zero determinant, identical texcoords
        send_triangle(make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'h10000, 17'h10000),
                      make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'h10000, 17'h10000),
                      make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'h10000, 17'h10000));
        // clamp high
        send_triangle(make_vertex('0, '0, '0, '0, '0),
                      make_vertex(24'h7fffff, 24'h7fffff, 24'h7fffff, 17'd1, '0),
                      make_vertex('0, '0, '0, '0, 17'd1));
        // clamp low
        send_triangle(make_vertex('0, '0, '0, '0, '0),
                      make_vertex(24'h800000, 24'h800000, 24'h800000, 17'd1, '0),
                      make_vertex('0, '0, '0, '0, 17'd1));
        // texcoords above one
        send_triangle(make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'h1ffff, '0),
                      make_vertex(rand_pos(), rand_pos(), rand_pos(), '0, 17'h1ffff),
                      make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'h1ffff, 17'h1ffff));
        // zero determinant, collinear texcoords
        send_triangle(make_vertex(rand_pos(), rand_pos(), rand_pos(), '0, '0),
                      make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'd100, 17'd200),
                      make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'd200, 17'd400));
        send_triangle(make_vertex(24'hffffff, 24'h000001, 24'h7fffff, 17'h1ffff, '0),
                      make_vertex('0, 24'hfffffe, 24'h800000, '0, 17'h1ffff),
                      make_vertex(rand_pos(), rand_pos(), rand_pos(), 17'h10000, 17'd1));
        drain();

        for (t = 0; t < RANDOM_TRIANGLES; t++)
        begin
            steady = (t >= 150 && t < 190);
            if (t == 90)
                hold_request = 1'b1;
            if (t == 200)
                drain();
            r = $urandom_range(0, 99);
            if (r < 40)
                kind = TRI_SPREAD;
            else if (r < 60)
                kind = TRI_LOCAL;
            else if (r < 70)
                kind = TRI_DEGENERATE;
            else if (r < 80)
                kind = TRI_TINY_DET;
            else if (r < 90)
                kind = TRI_WIDE_TEX;
            else
                kind = TRI_EXTREME;
            send_random_triangle(kind);
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d vertices and %0d triangles (%0d degenerate, %0d clamped)",
                 vertices_seen, triangles_seen, degenerate_seen, saturated_seen);
        $display("with random gaps on both sides, one long output hold and full drains");
        if (errors == 0 && pending == 0)
            $display("tb_triangle_tangent_bitangent passed");
        else
            $display("tb_triangle_tangent_bitangent failed");
        $finish;
    end

    // receiver
    initial
    begin
        int len;
        bit held_long;
        basis_stall = 1'b0;
        held_long = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request && !held_long)
            begin
                held_long = 1'b1;
                basis_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            len = pick_gap();
            if (len > 0)
            begin
                basis_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            basis_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((vertex_valid && !vertex_stall) || (basis_valid && !basis_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_triangle_tangent_bitangent failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

### filelist.f
sv/ttb_pkg.sv
sv/triangle_tangent_bitangent.sv
tb/sv/ttb_basis_checker.sv
tb/sv/tb_triangle_tangent_bitangent.sv
